// File: src/ffha_pkg.sv
// Package for the first-fit heap allocator: widths, codes, command and status records,
// controller state type. No dependencies.
`default_nettype none
package ffha_pkg;
	localparam int unsigned ARENA_UNITS_DEF  = 4096;
	localparam int unsigned HEADER_UNITS_DEF = 1;
	localparam int unsigned FIELD_W = 12;

	typedef enum logic [0:0] {
		FN_ALLOC   = 1'b0,
		FN_RELEASE = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_ZERO    = 2'd1,
		ST_FULL    = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_RD,
		S_EVAL,
		S_REL_PRD,
		S_REL_PEV,
		S_REL_NRD,
		S_REL_NEV,
		S_WR_CUR,
		S_FIX,
		S_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic    start;
		logic    init;
		logic    rd;
		logic    eval;
		logic    rel_prd;
		logic    rel_pev;
		logic    rel_nrd;
		logic    rel_nev;
		logic    wr_cur;
		logic    fix;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic    early;
		logic    rel_hit;
		logic    ev_wr;
		logic    ev_out;
		logic    need_fix;
	} dp_stat_t;
endpackage
`default_nettype wire

// File: src/ffha_if.sv
// Valid/ready channel interfaces for the allocator.
// Depends on ffha_pkg.
`default_nettype none
interface ffha_req_if;
	logic                        valid;
	logic                        ready;
	logic                        func;
	logic [ffha_pkg::FIELD_W-1:0] request_size;
	logic [ffha_pkg::FIELD_W-1:0] release_address;
	modport source (output valid, func, request_size, release_address, input ready);
	modport sink   (input valid, func, request_size, release_address, output ready);
endinterface

interface ffha_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [ffha_pkg::FIELD_W-1:0] payload_address;
	logic [1:0]                  status;
	modport source (output valid, payload_address, status, input ready);
	modport sink   (input valid, payload_address, status, output ready);
endinterface
`default_nettype wire

// File: src/ffha_ctrl.sv
// Controller FSM sequencing walks, splits and merges.
// Depends on ffha_pkg.
`default_nettype none
module ffha_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output ffha_pkg::dp_cmd_t      cmd,
	input  wire ffha_pkg::dp_stat_t stat
);
	import ffha_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_INIT;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: state_d = S_IDLE;
			S_IDLE: if (in_valid) state_d = stat.early ? S_OUT : S_RD;
			S_RD: state_d = S_EVAL;
			S_EVAL: begin
				if (stat.rel_hit) state_d = S_REL_PRD;
				else if (stat.ev_wr) state_d = S_WR_CUR;
				else if (stat.ev_out) state_d = S_OUT;
				else state_d = S_RD;
			end
			S_REL_PRD: state_d = S_REL_PEV;
			S_REL_PEV: state_d = S_REL_NRD;
			S_REL_NRD: state_d = S_REL_NEV;
			S_REL_NEV: state_d = S_WR_CUR;
			S_WR_CUR: state_d = stat.need_fix ? S_FIX : S_OUT;
			S_FIX: state_d = S_OUT;
			S_OUT: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_INIT: cmd.init = 1'b1;
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.start = in_valid;
			end
			S_RD: cmd.rd = 1'b1;
			S_EVAL: cmd.eval = 1'b1;
			S_REL_PRD: cmd.rel_prd = 1'b1;
			S_REL_PEV: cmd.rel_pev = 1'b1;
			S_REL_NRD: cmd.rel_nrd = 1'b1;
			S_REL_NEV: cmd.rel_nev = 1'b1;
			S_WR_CUR: cmd.wr_cur = 1'b1;
			S_FIX: cmd.fix = 1'b1;
			S_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.init, cmd.rd, cmd.eval, cmd.rel_prd, cmd.rel_pev,
			cmd.rel_nrd, cmd.rel_nev, cmd.wr_cur, cmd.fix}))
		else $error("multiple datapath commands");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("accept while result pending");
	a_rd_eval: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |=> cmd.eval) else $error("read not followed by eval");
endmodule
`default_nettype wire

// File: src/ffha_dp.sv
// Datapath: header memory, arena top, walk cursor, result registers.
// Depends on ffha_pkg.
`default_nettype none
module ffha_dp #(
	parameter int unsigned ARENA_UNITS  = ffha_pkg::ARENA_UNITS_DEF,
	parameter int unsigned HEADER_UNITS = ffha_pkg::HEADER_UNITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          func,
	input  wire logic [ffha_pkg::FIELD_W-1:0]  request_size,
	input  wire logic [ffha_pkg::FIELD_W-1:0]  release_address,
	input  wire ffha_pkg::dp_cmd_t             cmd,
	output ffha_pkg::dp_stat_t                 stat,
	output logic [ffha_pkg::FIELD_W-1:0]       payload_address,
	output logic [1:0]                         status
);
	import ffha_pkg::*;

	localparam int AW = $clog2(ARENA_UNITS);
	localparam int LW = ((AW > int'(FIELD_W)) ? AW : int'(FIELD_W)) + 2;
	localparam logic [LW-1:0] AU = LW'(ARENA_UNITS);
	localparam logic [LW-1:0] HU = LW'(HEADER_UNITS);

	typedef struct packed {
		logic [AW-1:0] size;
		logic [AW-1:0] prev;
		logic [AW-1:0] next;
		logic          free;
		logic          has_next;
	} hdr_t;

	hdr_t          mem [ARENA_UNITS];
	hdr_t          rd_q;
	logic [AW-1:0] raddr;
	logic          we;
	logic [AW-1:0] waddr;
	hdr_t          wdata;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	logic               func_q;
	logic [FIELD_W-1:0] n_q, rel_q;
	logic [LW-1:0]      top_q;
	logic [AW-1:0]      c_q;
	hdr_t               ch_q;
	logic [AW-1:0]      fix_addr_q, fix_prev_q;
	logic               fix_q;
	logic               first_q;

	logic [LW-1:0] total;
	logic [LW-1:0] cur_end;
	logic          fits;
	logic          split;
	logic          room;
	logic          rel_hit_w;
	logic [AW-1:0] nb_split;
	assign total = HU + LW'(n_q);
	assign cur_end = LW'(c_q) + HU + LW'(rd_q.size);
	assign fits = rd_q.free && (LW'(rd_q.size) >= LW'(n_q));
	assign split = fits && (LW'(rd_q.size) > total);
	assign room = (top_q + total) <= AU;
	assign nb_split = AW'(LW'(c_q) + total);
	assign rel_hit_w = func_q == FN_RELEASE && !first_q && (cur_end > LW'(rel_q));

	hdr_t split_hdr, app_hdr, lmerge_hdr, rmerge_hdr, freed_hdr;
	always_comb begin
		split_hdr = '0;
		split_hdr.size = AW'(LW'(rd_q.size) - total);
		split_hdr.prev = c_q;
		split_hdr.next = rd_q.next;
		split_hdr.free = 1'b1;
		split_hdr.has_next = rd_q.has_next;

		app_hdr = '0;
		app_hdr.size = AW'(n_q);
		app_hdr.prev = c_q;

		lmerge_hdr = rd_q;
		lmerge_hdr.size = AW'(LW'(rd_q.size) + LW'(ch_q.size) + HU);
		lmerge_hdr.next = ch_q.next;
		lmerge_hdr.has_next = ch_q.has_next;
		lmerge_hdr.free = 1'b1;

		rmerge_hdr = ch_q;
		rmerge_hdr.size = AW'(LW'(ch_q.size) + LW'(rd_q.size) + HU);
		rmerge_hdr.next = rd_q.next;
		rmerge_hdr.has_next = rd_q.has_next;

		freed_hdr = ch_q;
		freed_hdr.free = 1'b1;
	end

	always_comb begin
		raddr = c_q;
		we = 1'b0;
		waddr = c_q;
		wdata = rd_q;
		if (cmd.init) begin
			we = 1'b1;
			waddr = '0;
			wdata = '0;
		end else if (cmd.eval && func_q == FN_ALLOC) begin
			if (fits) begin
				we = 1'b1;
				wdata.free = 1'b0;
				if (split) begin
					wdata.size = AW'(n_q);
					wdata.next = nb_split;
					wdata.has_next = 1'b1;
				end
			end else if (!rd_q.has_next && room) begin
				we = 1'b1;
				wdata.next = AW'(top_q);
				wdata.has_next = 1'b1;
			end
		end else if (cmd.rel_prd) begin
			raddr = ch_q.prev;
		end else if (cmd.rel_nrd) begin
			raddr = ch_q.next;
		end else if (cmd.wr_cur) begin
			we = 1'b1;
			wdata = ch_q;
			raddr = fix_addr_q;
		end else if (cmd.fix) begin
			we = 1'b1;
			waddr = fix_addr_q;
			wdata.prev = fix_prev_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_q <= 1'b0;
			n_q <= '0;
			rel_q <= '0;
			top_q <= HU;
			c_q <= '0;
			ch_q <= '0;
			fix_addr_q <= '0;
			fix_prev_q <= '0;
			fix_q <= 1'b0;
			first_q <= 1'b1;
			status <= ST_DONE;
			payload_address <= '0;
		end else begin
			if (cmd.start) begin
				func_q <= func;
				n_q <= request_size;
				rel_q <= release_address;
				c_q <= '0;
				first_q <= 1'b1;
				fix_q <= 1'b0;
				status <= (func == FN_ALLOC) ? ST_ZERO : ST_IGNORED;
				payload_address <= '0;
			end
			if (cmd.eval) begin
				first_q <= 1'b0;
				if (func_q == FN_ALLOC) begin
					if (fits) begin
						status <= ST_DONE;
						payload_address <= FIELD_W'(LW'(c_q) + HU);
						if (split) begin
							c_q <= nb_split;
							ch_q <= split_hdr;
							fix_q <= rd_q.has_next;
							fix_addr_q <= rd_q.next;
							fix_prev_q <= nb_split;
						end
					end else if (!rd_q.has_next) begin
						if (room) begin
							status <= ST_DONE;
							payload_address <= FIELD_W'(top_q + HU);
							c_q <= AW'(top_q);
							ch_q <= app_hdr;
							top_q <= top_q + total;
							fix_q <= 1'b0;
						end else begin
							status <= ST_FULL;
							payload_address <= '0;
						end
					end else begin
						c_q <= rd_q.next;
					end
				end else begin
					if (rel_hit_w) begin
						ch_q <= rd_q;
						status <= ST_DONE;
						payload_address <= '0;
					end else if (!rd_q.has_next) begin
						status <= ST_IGNORED;
						payload_address <= '0;
					end else begin
						c_q <= rd_q.next;
					end
				end
			end
			if (cmd.rel_pev) begin
				if (rd_q.free) begin
					c_q <= ch_q.prev;
					ch_q <= lmerge_hdr;
					fix_q <= ch_q.has_next;
					fix_addr_q <= ch_q.next;
					fix_prev_q <= ch_q.prev;
				end else begin
					ch_q <= freed_hdr;
				end
			end
			if (cmd.rel_nev && ch_q.has_next && rd_q.free) begin
				ch_q <= rmerge_hdr;
				fix_q <= rd_q.has_next;
				fix_addr_q <= rd_q.next;
				fix_prev_q <= c_q;
			end
		end
	end

	always_comb begin
		stat.early    = (func == FN_ALLOC && request_size == '0) ||
			(func == FN_RELEASE && release_address == '0);
		stat.rel_hit  = rel_hit_w;
		stat.ev_wr    = func_q == FN_ALLOC && (split || (!fits && !rd_q.has_next && room));
		stat.ev_out   = (func_q == FN_ALLOC && ((fits && !split) ||
			(!fits && !rd_q.has_next && !room))) ||
			(func_q == FN_RELEASE && !rel_hit_w && !rd_q.has_next);
		stat.need_fix = fix_q;
	end
endmodule
`default_nettype wire

// File: src/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator: controller plus datapath.
// A zero-size allocate or a null release goes straight to the result; otherwise each header
// visited is read and then evaluated, then an append, split or release writes back headers.
// Throughput: one request at a time; next beat accepted the cycle after the result beat.
// Reset: asynchronous, active low; the init state after reset writes the dummy header at entry 0.
// Depends on ffha_pkg, ffha_if, ffha_ctrl, ffha_dp.
`default_nettype none
module first_fit_heap_allocator_top #(
	parameter int unsigned ARENA_UNITS  = ffha_pkg::ARENA_UNITS_DEF,
	parameter int unsigned HEADER_UNITS = ffha_pkg::HEADER_UNITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ffha_req_if.sink    req,
	ffha_rsp_if.source  rsp
);
	import ffha_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ffha_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.cmd, .stat
	);

	ffha_dp #(.ARENA_UNITS(ARENA_UNITS), .HEADER_UNITS(HEADER_UNITS)) u_dp (
		.clk, .arst_n,
		.func(req.func), .request_size(req.request_size),
		.release_address(req.release_address),
		.cmd, .stat,
		.payload_address(rsp.payload_address), .status(rsp.status)
	);
endmodule
`default_nettype wire

// File: tb/tb_first_fit_heap_allocator_top.sv
// Testbench for the first-fit heap allocator: directed table, then random
// allocate/release traffic checked against an in-bench chain predictor.
// Depends on ffha_pkg, ffha_if and first_fit_heap_allocator_top.
`timescale 1ns / 1ps
`default_nettype none
module tb_first_fit_heap_allocator_top;
	import ffha_pkg::*;

	localparam int unsigned ARENA = ARENA_UNITS_DEF;
	localparam int unsigned HDR   = HEADER_UNITS_DEF;
	localparam int NUM_ITEMS      = 1250;

	typedef struct {
		int unsigned size;
		int unsigned prv;
		int unsigned nxt;
		bit          is_free;
		bit          has_nxt;
	} hdr_t;

	typedef struct packed {
		logic [11:0] addr;
		status_t     st;
	} grant_t;

	typedef struct {
		func_t       fn;
		logic [11:0] size;
		logic [11:0] addr;
		bit          typed;
		logic [11:0] exp_addr;
		status_t     exp_st;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	ffha_req_if req ();
	ffha_rsp_if rsp ();

	first_fit_heap_allocator_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#200_000_000;
		$display("tb_first_fit_heap_allocator_top: done, errors");
		$finish;
	end

	hdr_t        chain [ARENA];
	int unsigned arena_top;
	grant_t      grants_due [$];
	int          errors = 0;
	int unsigned live_blocks [$];
	int          sent = 0;

	task automatic report(input string what);
		$display("MISMATCH: %s", what);
		errors++;
	endtask

	function automatic grant_t predict_alloc(input int unsigned n);
		int unsigned total, c, nb, guard;
		total = HDR + n;
		c = 0;
		guard = 0;
		if (n == 0) return '{12'd0, ST_ZERO};
		while (chain[c].size < n || !chain[c].is_free) begin
			guard++;
			if (guard > ARENA + 2) return '{12'd0, ST_FULL};
			if (!chain[c].has_nxt) begin
				nb = arena_top;
				if (nb + total > ARENA) return '{12'd0, ST_FULL};
				chain[nb] = '{n, c, 0, 1'b1, 1'b0};
				chain[c].nxt = nb;
				chain[c].has_nxt = 1'b1;
				arena_top = nb + total;
			end
			c = chain[c].nxt;
		end
		if (chain[c].size > total) begin
			nb = c + total;
			chain[nb] = '{chain[c].size - total, c, chain[c].nxt, 1'b1, chain[c].has_nxt};
			if (chain[c].has_nxt) chain[chain[c].nxt].prv = nb;
			chain[c].nxt = nb;
			chain[c].has_nxt = 1'b1;
			chain[c].size = n;
		end
		chain[c].is_free = 1'b0;
		return '{12'(c + HDR), ST_DONE};
	endfunction

	function automatic grant_t predict_release(input int unsigned a);
		int unsigned c, p, r, guard;
		c = 0;
		guard = 0;
		if (a == 0) return '{12'd0, ST_IGNORED};
		do begin
			guard++;
			if (!chain[c].has_nxt || guard > ARENA + 2) return '{12'd0, ST_IGNORED};
			c = chain[c].nxt;
		end while (c + HDR + chain[c].size <= a);
		chain[c].is_free = 1'b1;
		p = chain[c].prv;
		if (chain[p].is_free) begin
			chain[p].nxt = chain[c].nxt;
			chain[p].has_nxt = chain[c].has_nxt;
			if (chain[c].has_nxt) chain[chain[c].nxt].prv = p;
			chain[p].size += chain[c].size + HDR;
			c = p;
		end
		if (chain[c].has_nxt) begin
			r = chain[c].nxt;
			if (chain[r].is_free) begin
				chain[c].size += chain[r].size + HDR;
				if (chain[r].has_nxt) chain[chain[r].nxt].prv = c;
				chain[c].nxt = chain[r].nxt;
				chain[c].has_nxt = chain[r].has_nxt;
			end
		end
		return '{12'd0, ST_DONE};
	endfunction

	// receiver stall pattern
	int unsigned rx_phase = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			rx_phase <= 0;
		end else begin
			rx_phase <= rx_phase + 1;
			if (rx_phase[9:8] == 2'd0) rsp.ready <= 1'b1;
			else rsp.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		grant_t got, want;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = '{rsp.payload_address, status_t'(rsp.status)};
			if (grants_due.size() == 0) begin
				report($sformatf("unexpected beat addr=%0d st=%0d", got.addr, got.st));
			end else begin
				want = grants_due.pop_front();
				if (got.addr !== want.addr)
					report($sformatf("addr got %0d want %0d", got.addr, want.addr));
				if (got.st !== want.st)
					report($sformatf("status got %0d want %0d", got.st, want.st));
			end
		end
	end

	task automatic send(input func_t fn, input logic [11:0] sz, input logic [11:0] ad,
			input bit typed, input logic [11:0] ea, input status_t es);
		grant_t g;
		if ($urandom_range(0, 5) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.func <= fn;
		req.request_size <= sz;
		req.release_address <= ad;
		do @(posedge clk); while (!req.ready);
		sent++;
		g = (fn == FN_ALLOC) ? predict_alloc(sz) : predict_release(ad);
		if (typed && (g.addr !== ea || g.st !== es))
			report($sformatf("table row addr=%0d st=%0d vs typed %0d/%0d",
				g.addr, g.st, ea, es));
		if (fn == FN_ALLOC && g.st == ST_DONE) live_blocks.push_back(g.addr);
		grants_due.push_back(g);
	endtask

	row_t rows [$];
	initial begin
		int unsigned k, pick, wd;
		func_t fn;
		logic [11:0] sz, ad;
		bit paused;
		for (k = 0; k < ARENA; k++) chain[k] = '{0, 0, 0, 1'b0, 1'b0};
		arena_top = HDR;
		paused = 1'b0;
		req.valid = 1'b0;
		req.func = FN_ALLOC;
		req.request_size = '0;
		req.release_address = '0;
		rows = '{
			'{FN_RELEASE, 12'd0, 12'd5, 1'b1, 12'd0, ST_IGNORED},
			'{FN_ALLOC, 12'd0, 12'd0, 1'b1, 12'd0, ST_ZERO},
			'{FN_ALLOC, 12'd4095, 12'd0, 1'b1, 12'd0, ST_FULL},
			'{FN_ALLOC, 12'd4, 12'd0, 1'b1, 12'd2, ST_DONE},
			'{FN_ALLOC, 12'd8, 12'd0, 1'b1, 12'd7, ST_DONE},
			'{FN_ALLOC, 12'd3, 12'd0, 1'b1, 12'd16, ST_DONE},
			'{FN_RELEASE, 12'd0, 12'd0, 1'b1, 12'd0, ST_IGNORED},
			'{FN_RELEASE, 12'd0, 12'd4000, 1'b1, 12'd0, ST_IGNORED},
			'{FN_RELEASE, 12'd0, 12'd7, 1'b0, 12'd0, ST_DONE},
			'{FN_RELEASE, 12'd0, 12'd7, 1'b0, 12'd0, ST_DONE},
			'{FN_ALLOC, 12'd2, 12'd0, 1'b0, 12'd0, ST_DONE},
			'{FN_RELEASE, 12'd0, 12'd6, 1'b0, 12'd0, ST_DONE},
			'{FN_RELEASE, 12'd0, 12'd12, 1'b0, 12'd0, ST_DONE},
			'{FN_RELEASE, 12'd0, 12'd2, 1'b0, 12'd0, ST_DONE},
			'{FN_ALLOC, 12'd20, 12'd0, 1'b0, 12'd0, ST_DONE},
			'{FN_RELEASE, 12'd0, 12'd2, 1'b0, 12'd0, ST_DONE},
			'{FN_ALLOC, 12'd4000, 12'd0, 1'b0, 12'd0, ST_DONE},
			'{FN_ALLOC, 12'd100, 12'd0, 1'b0, 12'd0, ST_DONE},
			'{FN_RELEASE, 12'd0, 12'd4095, 1'b0, 12'd0, ST_DONE},
			'{FN_RELEASE, 12'd0, 12'd2730, 1'b0, 12'd0, ST_DONE},
			'{FN_RELEASE, 12'd0, 12'd1365, 1'b0, 12'd0, ST_DONE},
			'{FN_RELEASE, 12'd0, 12'd1, 1'b0, 12'd0, ST_DONE}
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send(rows[i].fn, rows[i].size, rows[i].addr, rows[i].typed,
				rows[i].exp_addr, rows[i].exp_st);
		while (sent < NUM_ITEMS) begin
			if (!paused && sent >= NUM_ITEMS / 2) begin
				paused = 1'b1;
				req.valid <= 1'b0;
				wait (grants_due.size() == 0);
				@(posedge clk);
			end
			pick = $urandom_range(0, 99);
			sz = '0;
			ad = '0;
			if (pick < 45) begin
				fn = FN_ALLOC;
				wd = $urandom_range(0, 9);
				sz = (wd == 0) ? 12'($urandom) : 12'($urandom_range(1, 40));
				if ($urandom_range(0, 60) == 0) sz = 0;
			end else if (pick < 85 && live_blocks.size() != 0) begin
				fn = FN_RELEASE;
				wd = $urandom_range(0, live_blocks.size() - 1);
				ad = 12'(live_blocks[wd]);
				live_blocks.delete(wd);
			end else begin
				fn = FN_RELEASE;
				ad = 12'($urandom);
			end
			if (fn == FN_ALLOC) ad = 12'($urandom);
			else sz = 12'($urandom);
			send(fn, sz, ad, 1'b0, 12'd0, ST_DONE);
			// long chains get slow; once arena_top passes 3500, free every live block
			if (arena_top > 3500 && live_blocks.size() != 0) begin
				while (live_blocks.size() != 0)
					send(FN_RELEASE, 12'($urandom), 12'(live_blocks.pop_front()),
						1'b0, 12'd0, ST_DONE);
			end
		end
		req.valid <= 1'b0;
		wait (grants_due.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("tb_first_fit_heap_allocator_top: done, clean");
		else
			$display("tb_first_fit_heap_allocator_top: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
